/* rtl/omnimix_pkg.sv */
package omnimix_pkg;

   // field widths
   localparam int CMD_W     = 15;
   localparam int HEADING_W = 17;
   localparam int WHEEL_W   = 17;
   localparam int STEP_W    = 16;
   localparam int TRIG_W    = 16;

   // cordic sizing
   localparam int TRIG_ITERATIONS = 16;
   localparam int ATAN_DEPTH      = 24;
   localparam int ITER_COUNT      = (TRIG_ITERATIONS < ATAN_DEPTH) ? TRIG_ITERATIONS
                                                                   : ATAN_DEPTH;
   localparam int ITER_W          = $clog2(ITER_COUNT);
   localparam int ATAN_IDX_W      = $clog2(ATAN_DEPTH);
   localparam int ATAN_W          = 27;
   localparam int CORDIC_W        = 34;
   localparam int ANGLE_W         = 30;

   typedef logic signed [CMD_W-1:0]     cmd_type;
   typedef logic signed [HEADING_W-1:0] heading_type;
   typedef logic signed [WHEEL_W-1:0]   wheel_type;
   typedef logic        [STEP_W-1:0]    step_type;
   typedef logic signed [TRIG_W-1:0]    trig_type;
   typedef logic signed [ANGLE_W-1:0]   angle_type;

   // atan(2^-i) in units of 2^-20 degree
   localparam logic [ATAN_W-1:0] ATAN_TAB [ATAN_DEPTH] = '{
      27'd47185920, 27'd27855475, 27'd14718068, 27'd7471121, 27'd3750058, 27'd1876857,
      27'd938658,   27'd469357,   27'd234682,   27'd117342,  27'd58671,   27'd29335,
      27'd14668,    27'd7334,     27'd3667,     27'd1833,    27'd917,     27'd458,
      27'd229,      27'd115,      27'd57,       27'd29,      27'd14,      27'd7
   };

   // cordic gain 0.607253 in Q30
   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

   // quarter and half turn in 2^-20 degree
   localparam logic signed [ANGLE_W-1:0] ANG_90  = 30'sd94371840;
   localparam logic signed [ANGLE_W-1:0] ANG_180 = 30'sd188743680;

   // heading wrap limits in centidegrees
   localparam int HALF_TURN_CDEG = 18000;
   localparam int FULL_TURN_CDEG = 36000;

   // 2^20 / 100 = 10485 + 76/100
   localparam int DEG_SCALE_INT  = 10485;
   localparam int DEG_SCALE_FRAC = 76;
   localparam int DEG_ROUND      = 50;
   // floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^21
   localparam int RECIP_100      = 5368710;
   localparam int RECIP_SHIFT    = 29;

   // cos 45 degrees in Q1.15
   localparam int COS45_Q15 = 23170;

   localparam int WHEEL_MAX = 65535;
   localparam int WHEEL_MIN = -65536;

   localparam logic [STEP_W-1:0] RAMP_STEP_RESET = 16'd40;

   // sequencer to cordic
   typedef struct packed {
      logic      start;
      logic      flip;
      angle_type angle;
   } cordic_req_type;

   // cordic to sequencer
   typedef struct packed {
      logic     done;
      trig_type sin_q15;
      trig_type cos_q15;
   } cordic_rsp_type;

endpackage

/* rtl/omni_chassis_wheel_mixer_ramp.sv */
// Omni wheel mixer with setpoint ramp for an X-configured chassis.
// Request channel (req_valid / req_stall): body speed command vx, vy, wz,
// heading offset in centidegrees and a hold flag. req_stall is low only when
// the sequencer is idle, so one request is worked on at a time.
// Response channel (rsp_valid / rsp_stall): the four ramped wheel setpoints.
// The response sits in an output register, so a new request is taken while
// a finished response is still stalled.
// A new request can be taken the cycle after the response is loaded. The
// time to a response is set by the shared CORDIC unit (one micro-rotation
// per cycle, 16 iterations plus rounding), the one shared multiplier (three
// angle, four rotation and two mix products) and the per-wheel target and
// ramp steps. The heading wrap adds or subtracts a full turn until in range.
// If the response is still stalled when the next one is done, the sequencer
// waits and holds req_stall high until the output register frees up.
// Reset (synchronous, active high) clears the stored setpoints to zero and
// sets the ramp step to 40. csr_wr_en writes the ramp step from csr_wr_data;
// it should only be written while the block is idle.
module omni_chassis_wheel_mixer_ramp (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  omnimix_pkg::step_type    csr_wr_data,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  omnimix_pkg::cmd_type     req_cmd_vx,
   input  omnimix_pkg::cmd_type     req_cmd_vy,
   input  omnimix_pkg::cmd_type     req_cmd_wz,
   input  omnimix_pkg::heading_type req_heading_offset,
   input  logic                     req_hold,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output omnimix_pkg::wheel_type   rsp_wheel_front_left,
   output omnimix_pkg::wheel_type   rsp_wheel_rear_left,
   output omnimix_pkg::wheel_type   rsp_wheel_rear_right,
   output omnimix_pkg::wheel_type   rsp_wheel_front_right
);
   import omnimix_pkg::*;

   localparam int P_W   = 48;
   localparam int M_W   = 24;
   localparam int MIX_W = 34;
   localparam int H_W   = HEADING_W + 1;
   localparam int D_W   = WHEEL_W + 2;

   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_WRAP    = 5'd1;
   localparam logic [4:0] ST_ANG1    = 5'd2;
   localparam logic [4:0] ST_ANG2    = 5'd3;
   localparam logic [4:0] ST_ANG3    = 5'd4;
   localparam logic [4:0] ST_ANG4    = 5'd5;
   localparam logic [4:0] ST_TRIG    = 5'd6;
   localparam logic [4:0] ST_ROT1    = 5'd7;
   localparam logic [4:0] ST_ROT2    = 5'd8;
   localparam logic [4:0] ST_ROT3    = 5'd9;
   localparam logic [4:0] ST_ROT4    = 5'd10;
   localparam logic [4:0] ST_ROT5    = 5'd11;
   localparam logic [4:0] ST_MIX1    = 5'd12;
   localparam logic [4:0] ST_MIX2    = 5'd13;
   localparam logic [4:0] ST_WHEEL_T = 5'd14;
   localparam logic [4:0] ST_WHEEL_R = 5'd15;
   localparam logic [4:0] ST_DONE    = 5'd16;

   logic [4:0]               state_ff, state_in;
   step_type                 ramp_ff;
   cmd_type                  vx_ff, vy_ff, wz_ff;
   logic                     hold_ff;
   logic signed [H_W-1:0]    h_ff;
   logic [14:0]              mag;
   logic signed [H_W-1:0]    h_abs;
   logic [20:0]              frac_ff;
   logic [27:0]              base_ff;
   logic [27:0]              q_ang;
   angle_type                z_signed, z_fold;
   logic                     flip;
   logic signed [M_W-1:0]    mul_a, mul_b;
   logic signed [P_W-1:0]    p_ff, acc_ff;
   wheel_type                rx_ff, ry_ff;
   logic signed [MIX_W-1:0]  a_ff, b_term, sa, sb, wz_term, mix_sum;
   wheel_type                tgt_ff, tgt_in;
   logic [1:0]               k_ff;
   wheel_type                setp_ff [4];
   wheel_type                out_ff [4];
   wheel_type                cur, setp_in;
   logic signed [D_W-1:0]    diff, step_s;
   logic                     rsp_valid_ff;
   logic                     load_rsp;
   cordic_req_type           cor_req;
   cordic_rsp_type           cor_rsp;

   // product to Q15 integer, truncated toward zero
   function automatic wheel_type trunc_q15(input logic signed [P_W-1:0] v);
      logic signed [P_W-1:0] t;
      t = v[P_W-1] ? v + P_W'(32767) : v;
      return WHEEL_W'(t >>> 15);
   endfunction

   // divide by 2^15 rounding ties away from zero, then clamp to wheel range
   function automatic wheel_type round_clamp(input logic signed [MIX_W-1:0] v);
      logic signed [MIX_W-1:0] r;
      logic signed [D_W-1:0]   t;
      wheel_type               w;
      r = v[MIX_W-1] ? v + MIX_W'(16383) : v + MIX_W'(16384);
      t = D_W'(r >>> 15);
      if (t > WHEEL_MAX) begin
         w = WHEEL_W'(WHEEL_MAX);
      end else if (t < WHEEL_MIN) begin
         w = WHEEL_W'(WHEEL_MIN);
      end else begin
         w = WHEEL_W'(t);
      end
      return w;
   endfunction

   omnimix_cordic u_cordic (
      .clock   (clock),
      .reset   (reset),
      .cor_req (cor_req),
      .cor_rsp (cor_rsp)
   );

   // heading magnitude and angle conversion
   always_comb begin
      h_abs    = h_ff[H_W-1] ? -h_ff : h_ff;
      mag      = 15'(h_abs);
      q_ang    = base_ff + {9'b0, p_ff[P_W-1:RECIP_SHIFT]};
      z_signed = h_ff[H_W-1] ? -$signed({2'b0, q_ang}) : $signed({2'b0, q_ang});
      flip     = 1'b0;
      z_fold   = z_signed;
      if (z_signed > ANG_90) begin
         z_fold = z_signed - ANG_180;
         flip   = 1'b1;
      end else if (z_signed < -ANG_90) begin
         z_fold = z_signed + ANG_180;
         flip   = 1'b1;
      end
      cor_req.start = (state_ff == ST_ANG4);
      cor_req.flip  = flip;
      cor_req.angle = z_fold;
   end

   // shared multiplier operand select
   always_comb begin
      unique case (state_ff) inside
         ST_ANG1: begin
            mul_a = $signed({9'b0, mag});
            mul_b = M_W'(DEG_SCALE_FRAC);
         end
         ST_ANG2: begin
            mul_a = $signed({9'b0, mag});
            mul_b = M_W'(DEG_SCALE_INT);
         end
         ST_ANG3: begin
            mul_a = $signed({3'b0, frac_ff});
            mul_b = M_W'(RECIP_100);
         end
         ST_ROT1: begin
            mul_a = M_W'(vx_ff);
            mul_b = M_W'(cor_rsp.cos_q15);
         end
         ST_ROT2: begin
            mul_a = M_W'(vy_ff);
            mul_b = M_W'(cor_rsp.sin_q15);
         end
         ST_ROT3: begin
            mul_a = M_W'(vy_ff);
            mul_b = M_W'(cor_rsp.cos_q15);
         end
         ST_ROT4: begin
            mul_a = M_W'(vx_ff);
            mul_b = M_W'(cor_rsp.sin_q15);
         end
         ST_MIX1: begin
            mul_a = M_W'(rx_ff);
            mul_b = M_W'(COS45_Q15);
         end
         ST_MIX2, ST_WHEEL_T, ST_WHEEL_R: begin
            mul_a = M_W'(ry_ff);
            mul_b = M_W'(COS45_Q15);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      p_ff <= mul_a * mul_b;
   end

   // wheel target: signs of the two mix terms follow the wheel position
   always_comb begin
      b_term  = MIX_W'(p_ff);
      sa      = (k_ff == 2'd1 || k_ff == 2'd2) ? -a_ff : a_ff;
      sb      = k_ff[1] ? b_term : -b_term;
      wz_term = MIX_W'(wz_ff) <<< 15;
      mix_sum = sa + sb + wz_term;
      tgt_in  = round_clamp(mix_sum);
   end

   // slew the stored setpoint toward the target without overshoot
   always_comb begin
      cur    = setp_ff[k_ff];
      diff   = D_W'(tgt_ff) - D_W'(cur);
      step_s = $signed({{(D_W-STEP_W){1'b0}}, ramp_ff});
      if (!diff[D_W-1]) begin
         setp_in = (diff > step_s) ? WHEEL_W'(D_W'(cur) + step_s) : tgt_ff;
      end else begin
         setp_in = (-diff > step_s) ? WHEEL_W'(D_W'(cur) - step_s) : tgt_ff;
      end
   end

   assign load_rsp = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   // sequencer
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:    if (req_valid) state_in = ST_WRAP;
         ST_WRAP: begin
            if (h_ff >= -HALF_TURN_CDEG && h_ff < HALF_TURN_CDEG) begin
               state_in = ST_ANG1;
            end
         end
         ST_ANG1:    state_in = ST_ANG2;
         ST_ANG2:    state_in = ST_ANG3;
         ST_ANG3:    state_in = ST_ANG4;
         ST_ANG4:    state_in = ST_TRIG;
         ST_TRIG:    if (cor_rsp.done) state_in = ST_ROT1;
         ST_ROT1:    state_in = ST_ROT2;
         ST_ROT2:    state_in = ST_ROT3;
         ST_ROT3:    state_in = ST_ROT4;
         ST_ROT4:    state_in = ST_ROT5;
         ST_ROT5:    state_in = ST_MIX1;
         ST_MIX1:    state_in = ST_MIX2;
         ST_MIX2:    state_in = ST_WHEEL_T;
         ST_WHEEL_T: state_in = ST_WHEEL_R;
         ST_WHEEL_R: state_in = (k_ff == 2'd3) ? ST_DONE : ST_WHEEL_T;
         ST_DONE:    if (load_rsp) state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ramp_ff      <= RAMP_STEP_RESET;
         rsp_valid_ff <= 1'b0;
         k_ff         <= '0;
         for (int i = 0; i < 4; i++) begin
            setp_ff[i] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            ramp_ff <= csr_wr_data;
         end
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
         if (state_ff == ST_MIX2) begin
            k_ff <= '0;
         end else if (state_ff == ST_WHEEL_R) begin
            setp_ff[k_ff] <= setp_in;
            k_ff          <= k_ff + 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            vx_ff   <= req_cmd_vx;
            vy_ff   <= req_cmd_vy;
            wz_ff   <= req_hold ? '0 : req_cmd_wz;
            hold_ff <= req_hold;
            h_ff    <= H_W'(req_heading_offset);
         end
         ST_WRAP: begin
            if (h_ff < -HALF_TURN_CDEG) begin
               h_ff <= H_W'(h_ff + FULL_TURN_CDEG);
            end else if (h_ff >= HALF_TURN_CDEG) begin
               h_ff <= H_W'(h_ff - FULL_TURN_CDEG);
            end
         end
         ST_ANG2:    frac_ff <= p_ff[20:0] + 21'(DEG_ROUND);
         ST_ANG3:    base_ff <= p_ff[27:0];
         ST_ROT2:    acc_ff  <= p_ff;
         ST_ROT3:    rx_ff   <= hold_ff ? '0 : trunc_q15(acc_ff + p_ff);
         ST_ROT4:    acc_ff  <= p_ff;
         ST_ROT5:    ry_ff   <= hold_ff ? '0 : trunc_q15(acc_ff - p_ff);
         ST_MIX2:    a_ff    <= MIX_W'(p_ff);
         ST_WHEEL_T: tgt_ff  <= tgt_in;
         default: begin
         end
      endcase
      if (load_rsp) begin
         for (int i = 0; i < 4; i++) begin
            out_ff[i] <= setp_ff[i];
         end
      end
   end

   assign req_stall             = (state_ff != ST_IDLE);
   assign rsp_valid             = rsp_valid_ff;
   assign rsp_wheel_front_left  = out_ff[0];
   assign rsp_wheel_rear_left   = out_ff[1];
   assign rsp_wheel_rear_right  = out_ff[2];
   assign rsp_wheel_front_right = out_ff[3];

   // trig results only come back while the sequencer waits for them
   a_trig_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      cor_rsp.done |-> state_ff == ST_TRIG)
      else $error("cordic done outside trig wait");

   // a response only appears after the sequencer finished a request
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == ST_DONE))
      else $error("response without finished request");

   // a free output register is always loaded and the sequencer goes idle
   a_done_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && !(rsp_valid && rsp_stall)) |=>
         (rsp_valid && state_ff == ST_IDLE))
      else $error("finished request not delivered");

   // hold zeroes the rotated speeds before mixing
   a_hold_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MIX1 && hold_ff) |-> (rx_ff == '0 && ry_ff == '0 && wz_ff == '0))
      else $error("hold did not zero speeds");

endmodule

/* rtl/omnimix_cordic.sv */
module omnimix_cordic (
   input  logic                       clock,
   input  logic                       reset,
   input  omnimix_pkg::cordic_req_type cor_req,
   output omnimix_pkg::cordic_rsp_type cor_rsp
);
   import omnimix_pkg::*;

   logic signed [CORDIC_W-1:0] x_ff, y_ff, x_in, y_in;
   angle_type                  z_ff, z_in;
   logic [ITER_W-1:0]          iter_ff;
   logic                       busy_ff, fin_ff, done_ff, flip_ff;
   trig_type                   sin_ff, cos_ff;
   logic signed [CORDIC_W-1:0] dx, dy;
   angle_type                  atan_step;

   // Q30 to Q15, ties away from zero, saturate, optional negate
   function automatic trig_type round_sat(input logic signed [CORDIC_W-1:0] v,
                                          input logic neg);
      logic signed [CORDIC_W-1:0] r;
      logic signed [CORDIC_W-16:0] sh;
      trig_type s;
      r  = v[CORDIC_W-1] ? v + CORDIC_W'(16383) : v + CORDIC_W'(16384);
      sh = (CORDIC_W-15)'(r >>> 15);
      if (sh > 32767) begin
         s = 16'sd32767;
      end else if (sh < -32767) begin
         s = -16'sd32767;
      end else begin
         s = TRIG_W'(sh);
      end
      return neg ? -s : s;
   endfunction

   // one micro-rotation, direction from the sign of the residual angle
   always_comb begin
      dx        = y_ff >>> iter_ff;
      dy        = x_ff >>> iter_ff;
      atan_step = $signed({{(ANGLE_W-ATAN_W){1'b0}}, ATAN_TAB[ATAN_IDX_W'(iter_ff)]});
      if (!z_ff[ANGLE_W-1]) begin
         x_in = x_ff - dx;
         y_in = y_ff + dy;
         z_in = z_ff - atan_step;
      end else begin
         x_in = x_ff + dx;
         y_in = y_ff - dy;
         z_in = z_ff + atan_step;
      end
   end

   // iteration control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         fin_ff  <= 1'b0;
         if (cor_req.start) begin
            busy_ff <= 1'b1;
            iter_ff <= '0;
         end else if (busy_ff) begin
            if (iter_ff == ITER_W'(ITER_COUNT - 1)) begin
               busy_ff <= 1'b0;
               fin_ff  <= 1'b1;
            end else begin
               iter_ff <= iter_ff + 1'b1;
            end
         end else if (fin_ff) begin
            done_ff <= 1'b1;
         end
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (cor_req.start) begin
         x_ff    <= CORDIC_GAIN;
         y_ff    <= '0;
         z_ff    <= cor_req.angle;
         flip_ff <= cor_req.flip;
      end else if (busy_ff) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
      if (fin_ff) begin
         cos_ff <= round_sat(x_ff, flip_ff);
         sin_ff <= round_sat(y_ff, flip_ff);
      end
   end

   assign cor_rsp.done    = done_ff;
   assign cor_rsp.sin_q15 = sin_ff;
   assign cor_rsp.cos_q15 = cos_ff;

endmodule

/* dv/omni_chassis_wheel_mixer_ramp_tb.sv */
module omni_chassis_wheel_mixer_ramp_tb;
   import omnimix_pkg::*;

   localparam int     CYCLE_LIMIT  = 600000;
   localparam int     DRAIN_CYCLES = 60;
   localparam longint HALF_TURN    = 18000;
   localparam longint FULL_TURN    = 36000;
   localparam longint QUARTER_ANG  = 94371840;
   localparam longint HALF_ANG     = 188743680;
   localparam longint GAIN_Q30     = 652032874;
   localparam longint DIAG_Q15     = 23170;
   localparam longint SETPOINT_MAX = 65535;
   localparam longint SETPOINT_MIN = -65536;
   localparam longint STEP_AT_RESET = 40;
   localparam int     ARCTAN_DEPTH = 24;

   // arctangent of 2^-i in units of 2^-20 degree
   localparam longint ARCTAN_STEP [ARCTAN_DEPTH] = '{
      47185920, 27855475, 14718068, 7471121, 3750058, 1876857,
      938658, 469357, 234682, 117342, 58671, 29335,
      14668, 7334, 3667, 1833, 917, 458,
      229, 115, 57, 29, 14, 7
   };

   typedef struct packed {
      cmd_type     vx;
      cmd_type     vy;
      cmd_type     wz;
      heading_type heading;
      logic        hold;
   } chassis_cmd_type;

   typedef struct packed {
      wheel_type front_left;
      wheel_type rear_left;
      wheel_type rear_right;
      wheel_type front_right;
   } wheel_set_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   step_type    csr_wr_data = '0;
   logic        req_valid = 1'b0;
   logic        req_stall;
   cmd_type     req_cmd_vx = '0;
   cmd_type     req_cmd_vy = '0;
   cmd_type     req_cmd_wz = '0;
   heading_type req_heading_offset = '0;
   logic        req_hold = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   wheel_type   rsp_wheel_front_left;
   wheel_type   rsp_wheel_rear_left;
   wheel_type   rsp_wheel_rear_right;
   wheel_type   rsp_wheel_front_right;

   chassis_cmd_type pending_cmds[$];
   wheel_set_type   wheel_expect_q[$];
   longint       setpoint_state[4] = '{0, 0, 0, 0};
   longint       ramp_step_model = STEP_AT_RESET;
   int           issued_count = 0;
   int           accepted_count = 0;
   int           mismatch_count = 0;
   int           cycle_count = 0;
   int           send_idle_pct = 0;
   int           stall_pct = 0;
   bit           req_taken = 1'b0;

   omni_chassis_wheel_mixer_ramp dut (
      .clock                 (clock),
      .reset                 (reset),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_cmd_vx            (req_cmd_vx),
      .req_cmd_vy            (req_cmd_vy),
      .req_cmd_wz            (req_cmd_wz),
      .req_heading_offset    (req_heading_offset),
      .req_hold              (req_hold),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_wheel_front_left  (rsp_wheel_front_left),
      .rsp_wheel_rear_left   (rsp_wheel_rear_left),
      .rsp_wheel_rear_right  (rsp_wheel_rear_right),
      .rsp_wheel_front_right (rsp_wheel_front_right)
   );

   // clock
   initial begin
      forever #5 clock = ~clock;
   end

   // divide by 2^s, round half away from zero
   function automatic longint round_div(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = (mag + (longint'(1) << (s - 1))) >> s;
      return (v < 0) ? -mag : mag;
   endfunction

   // divide by 2^s, toward zero
   function automatic longint trunc_div(longint v, int s);
      longint mag;
      mag = (v < 0) ? -v : v;
      mag = mag >> s;
      return (v < 0) ? -mag : mag;
   endfunction

   function automatic longint clip_q15(longint v);
      if (v > 32767) return 32767;
      if (v < -32767) return -32767;
      return v;
   endfunction

   // sine and cosine of a wrapped heading in centidegrees, Q1.15
   function automatic void heading_sin_cos(input longint cdeg, output longint sin_q15,
                                           output longint cos_q15);
      longint mag, z, x, y, dx, dy;
      bit     folded;
      int     iters;
      mag = (cdeg < 0) ? -cdeg : cdeg;
      z = (mag * 1048576 + 50) / 100;
      if (cdeg < 0) z = -z;
      folded = 1'b0;
      if (z > QUARTER_ANG) begin
         z = z - HALF_ANG;
         folded = 1'b1;
      end else if (z < -QUARTER_ANG) begin
         z = z + HALF_ANG;
         folded = 1'b1;
      end
      x = GAIN_Q30;
      y = 0;
      iters = (TRIG_ITERATIONS < ARCTAN_DEPTH) ? TRIG_ITERATIONS : ARCTAN_DEPTH;
      // rotation mode, floor shifts
      for (int i = 0; i < iters; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - ARCTAN_STEP[i];
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + ARCTAN_STEP[i];
         end
      end
      cos_q15 = clip_q15(round_div(x, 15));
      sin_q15 = clip_q15(round_div(y, 15));
      if (folded) begin
         cos_q15 = -cos_q15;
         sin_q15 = -sin_q15;
      end
   endfunction

   // one control tick: rotate, mix, ramp the stored setpoints
   function automatic wheel_set_type ramp_wheel_setpoints(chassis_cmd_type c);
      longint        vx, vy, wz, h, s, co, rx, ry, a, b, t, cur;
      longint        target[4];
      wheel_set_type ws;
      vx = c.vx;
      vy = c.vy;
      wz = c.wz;
      h = c.heading;
      while (h < -HALF_TURN) h = h + FULL_TURN;
      while (h >= HALF_TURN) h = h - FULL_TURN;
      heading_sin_cos(h, s, co);
      rx = trunc_div(vx * co + vy * s, 15);
      ry = trunc_div(vy * co - vx * s, 15);
      if (c.hold) begin
         rx = 0;
         ry = 0;
         wz = 0;
      end
      a = rx * DIAG_Q15;
      b = ry * DIAG_Q15;
      target[0] = round_div(a - b + wz * 32768, 15);
      target[1] = round_div(-a - b + wz * 32768, 15);
      target[2] = round_div(-a + b + wz * 32768, 15);
      target[3] = round_div(a + b + wz * 32768, 15);
      for (int k = 0; k < 4; k++) begin
         t = target[k];
         if (t > SETPOINT_MAX) t = SETPOINT_MAX;
         if (t < SETPOINT_MIN) t = SETPOINT_MIN;
         cur = setpoint_state[k];
         // slew without overshoot
         if (t - cur >= 0) begin
            cur = cur + ramp_step_model;
            if (cur > t) cur = t;
         end else begin
            cur = cur - ramp_step_model;
            if (cur < t) cur = t;
         end
         setpoint_state[k] = cur;
      end
      ws.front_left  = wheel_type'(setpoint_state[0]);
      ws.rear_left   = wheel_type'(setpoint_state[1]);
      ws.rear_right  = wheel_type'(setpoint_state[2]);
      ws.front_right = wheel_type'(setpoint_state[3]);
      return ws;
   endfunction

   task automatic check_wheel(string name, wheel_type want, wheel_type got);
      if (want !== got) begin
         mismatch_count++;
         $display("%0t %s expected %0d actual %0d", $time, name, want, got);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      chassis_cmd_type c;
      if (!reset && (!req_valid || req_taken)) begin
         if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            c = pending_cmds.pop_front();
            req_valid          <= 1'b1;
            req_cmd_vx         <= c.vx;
            req_cmd_vy         <= c.vy;
            req_cmd_wz         <= c.wz;
            req_heading_offset <= c.heading;
            req_hold           <= c.hold;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response back-pressure
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   // monitor: predict on each accepted request, check each accepted response
   always @(posedge clock) begin
      chassis_cmd_type c;
      wheel_set_type   want;
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Mismatches found");
         $finish;
      end
      if (reset) begin
         for (int k = 0; k < 4; k++) setpoint_state[k] = 0;
         ramp_step_model = STEP_AT_RESET;
         req_taken = 1'b0;
      end else begin
         if (csr_wr_en) ramp_step_model = csr_wr_data;
         req_taken = req_valid && !req_stall;
         if (req_taken) begin
            c.vx      = req_cmd_vx;
            c.vy      = req_cmd_vy;
            c.wz      = req_cmd_wz;
            c.heading = req_heading_offset;
            c.hold    = req_hold;
            accepted_count++;
            wheel_expect_q.push_back(ramp_wheel_setpoints(c));
         end
         if (rsp_valid && !rsp_stall) begin
            if (wheel_expect_q.size() == 0) begin
               mismatch_count++;
               $display("%0t unexpected response expected none actual %0d %0d %0d %0d", $time,
                        rsp_wheel_front_left, rsp_wheel_rear_left, rsp_wheel_rear_right,
                        rsp_wheel_front_right);
            end else begin
               want = wheel_expect_q.pop_front();
               check_wheel("front_left", want.front_left, rsp_wheel_front_left);
               check_wheel("rear_left", want.rear_left, rsp_wheel_rear_left);
               check_wheel("rear_right", want.rear_right, rsp_wheel_rear_right);
               check_wheel("front_right", want.front_right, rsp_wheel_front_right);
            end
         end
      end
   end

   task automatic push_request(int vx, int vy, int wz, int heading, bit hold);
      chassis_cmd_type c;
      c.vx      = cmd_type'(vx);
      c.vy      = cmd_type'(vy);
      c.wz      = cmd_type'(wz);
      c.heading = heading_type'(heading);
      c.hold    = hold;
      pending_cmds.push_back(c);
      issued_count++;
   endtask

   // speeds lean toward the extremes now and then
   function automatic cmd_type random_speed();
      case ($urandom_range(9))
         0: return cmd_type'(-16384);
         1: return cmd_type'(16383);
         2: return cmd_type'($urandom_range(3) - 1);
         default: return cmd_type'($urandom);
      endcase
   endfunction

   // mostly in range, some full width, some near the fold and wrap points
   function automatic heading_type random_heading();
      int spots[8] = '{9000, -9000, 18000, -18000, 0, 36000, -36000, 27000};
      case ($urandom_range(9))
         6, 7: return heading_type'($urandom);
         8: return heading_type'(spots[$urandom_range(7)] + int'($urandom_range(4)) - 2);
         default: return heading_type'(int'($urandom_range(71999)) - 36000);
      endcase
   endfunction

   // runs of one command let the setpoints ramp all the way and settle
   task automatic queue_random_requests(int count);
      chassis_cmd_type c;
      int              run_len, made;
      made = 0;
      while (made < count) begin
         c.vx      = random_speed();
         c.vy      = random_speed();
         c.wz      = random_speed();
         c.heading = random_heading();
         c.hold    = ($urandom_range(9) == 0);
         case ($urandom_range(9))
            0, 1, 2, 3, 4, 5: run_len = $urandom_range(12, 3);
            6, 7: run_len = 1;
            default: begin
               c.hold  = 1'b1;
               run_len = $urandom_range(8, 2);
            end
         endcase
         for (int k = 0; k < run_len && made < count; k++) begin
            pending_cmds.push_back(c);
            issued_count++;
            made++;
         end
      end
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_cmds.size() > 0 || accepted_count != issued_count ||
             wheel_expect_q.size() > 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_ramp_step(step_type value);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_phase(step_type value, int count);
      write_ramp_step(value);
      queue_random_requests(count);
      wait_drained();
   endtask

   // stimulus
   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_idle_pct = 32;
      stall_pct     = 55;

      // directed: extremes, quadrant folds, wrap of out-of-range headings, hold
      push_request(16383, 16383, 16383, 0, 0);
      push_request(-16384, -16384, -16384, 0, 0);
      push_request(16383, -16384, 16383, 9000, 0);
      push_request(-16384, 16383, -16384, -9000, 0);
      push_request(16383, 0, 0, 9001, 0);
      push_request(16383, 0, 0, -9001, 0);
      push_request(0, 16383, 0, 17999, 0);
      push_request(0, 16383, 0, -18000, 0);
      push_request(16383, 16383, 0, 18000, 0);
      push_request(16383, -1, 1, -18001, 0);
      push_request(16383, 16383, 16383, 35999, 0);
      push_request(-16384, 16383, 0, -36000, 0);
      push_request(16383, 16383, 16383, 65535, 0);
      push_request(-16384, -16384, -16384, -65536, 0);
      push_request(16383, 16383, 16383, 4500, 1);
      push_request(-16384, -16384, -16384, -13500, 1);
      push_request(0, 0, 0, 0, 0);
      push_request(1, -1, -1, 1, 0);
      push_request(-1, 1, 1, -1, 0);
      push_request(16383, -16384, 0, 36000, 0);
      push_request(0, 0, 16383, -54000, 0);
      push_request(5000, -7000, 300, 12345, 0);
      wait_drained();

      // sender idles less than the receiver stalls
      run_phase(16'hFFFF, 170);
      run_phase(16'd0, 40);

      // the other way round
      send_idle_pct = 55;
      stall_pct     = 32;
      run_phase(16'd1, 60);
      run_phase(step_type'($urandom_range(4000, 2)), 230);

      // no idling on either side
      send_idle_pct = 0;
      stall_pct     = 0;
      run_phase(16'd600, 200);
      run_phase(16'd40, 120);
      run_phase(step_type'($urandom), 130);

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
